[src/flfa_pkg.sv]
// Package for the free-list fit allocator.
// Holds the operation, status, policy, cell and controller codes.
// No dependencies; every other file imports it.
package flfa_pkg;

  // Default geometry and fixed field widths.
  localparam int MaxBlocksDefault = 64;
  localparam int SizeBitsDefault  = 32;
  localparam int RandBits         = 16;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_APPEND   = 2'd1,
    OP_ALLOCATE = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Placement policies.
  localparam logic [2:0] POL_FIRST  = 3'd0;
  localparam logic [2:0] POL_NEXT   = 3'd1;
  localparam logic [2:0] POL_BEST   = 3'd2;
  localparam logic [2:0] POL_WORST  = 3'd3;
  localparam logic [2:0] POL_RANDOM = 3'd4;

  // What every cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_CLOSE  = 2'd2,
    CELL_APPEND = 2'd3
  } cell_mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SCAN   = 3'd1,
    S_DIV    = 3'd2,
    S_PICK   = 3'd3,
    S_EVAL   = 3'd4,
    S_CLOSE  = 3'd5,
    S_UPDATE = 3'd6,
    S_DONE   = 3'd7
  } state_t;

endpackage

[src/flfa_if.sv]
// Handshake interfaces of the free-list fit allocator: request, result
// and configuration channels. Depends on flfa_pkg.
interface flfa_in_if import flfa_pkg::*; #(
  parameter int SizeBits = SizeBitsDefault
);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [SizeBits-1:0] size_value;
  logic [RandBits-1:0] random_value;
  modport source(output valid, opcode, size_value, random_value, input ready);
  modport sink(input valid, opcode, size_value, random_value, output ready);
endinterface

interface flfa_out_if import flfa_pkg::*; #(
  parameter int SizeBits = SizeBitsDefault,
  parameter int IdxBits  = 6,
  parameter int CntBits  = 7
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [IdxBits-1:0]  chosen_index;
  logic [SizeBits-1:0] remaining_size;
  logic                block_removed;
  logic [CntBits-1:0]  block_count_out;
  modport source(output valid, status, chosen_index, remaining_size, block_removed,
                 block_count_out, input ready);
  modport sink(input valid, status, chosen_index, remaining_size, block_removed,
               block_count_out, output ready);
endinterface

interface flfa_cfg_if import flfa_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] fit_policy;
  modport source(output valid, fit_policy, input ready);
  modport sink(input valid, fit_policy, output ready);
endinterface

[src/flfa_cell.sv]
// One cell of the block-size chain: holds a single table entry.
// Depends on flfa_pkg for the cell mode codes.
module flfa_cell import flfa_pkg::*; #(
  parameter int SIZE_BITS = SizeBitsDefault,
  parameter int IDX_BITS  = 6,
  parameter int CELL_POS  = 0
) (
  input  logic                 clk,
  input  cell_mode_t           mode,
  input  logic [IDX_BITS-1:0]  pos,
  input  logic [SIZE_BITS-1:0] data,
  input  logic [SIZE_BITS-1:0] nbr,
  output logic [SIZE_BITS-1:0] value
);

  localparam logic [IDX_BITS-1:0] MyPos = IDX_BITS'(CELL_POS);

  // Rotate takes the neighbour's entry, close does so from the gap upward,
  // append loads the new size into the addressed cell.
  always_ff @(posedge clk) begin
    case (mode)
      CELL_ROTATE: value <= nbr;
      CELL_CLOSE: begin
        if (MyPos >= pos) value <= nbr;
      end
      CELL_APPEND: begin
        if (MyPos == pos) value <= data;
      end
      default: value <= value;
    endcase
  end

endmodule

[src/flfa_mod.sv]
// Restoring remainder unit: one dividend bit per cycle.
// Depends on flfa_pkg for the random value width.
module flfa_mod import flfa_pkg::*; #(
  parameter int CNT_BITS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RandBits-1:0] dividend,
  input  logic [CNT_BITS-1:0] divisor,
  output logic                done,
  output logic [CNT_BITS-1:0] rem
);

  localparam int ItBits = $clog2(RandBits);

  logic                busy;
  logic [ItBits-1:0]   iter;
  logic [RandBits-1:0] quo;
  logic [CNT_BITS:0]   rem_sh;

  assign rem_sh = {rem, quo[RandBits-1]};

  // Shift in one bit and subtract the divisor when it goes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, divisor}) rem <= CNT_BITS'(rem_sh - {1'b0, divisor});
        else rem <= rem_sh[CNT_BITS-1:0];
        quo  <= quo << 1;
        iter <= iter + 1'b1;
        if (iter == ItBits'(RandBits - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/free_list_fit_allocator.sv]
// Free-list fit allocator top level: controller, chain of cells, remainder unit.
// Depends on flfa_pkg, the flfa interfaces, flfa_cell and flfa_mod.
//
// The free table sits in a ring of MAX_BLOCKS cells that rotates one place per
// cycle past a head cell during a table walk. Clear, append and unknown words
// need no walk. An allocation takes one walk to choose the block, then closes
// the gap on an exact fit or takes a second walk to shrink the block. Random
// fit adds a remainder step and another walk.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken.
module free_list_fit_allocator import flfa_pkg::*; #(
  parameter int MAX_BLOCKS = MaxBlocksDefault,
  parameter int SIZE_BITS  = SizeBitsDefault
) (
  input logic     clk,
  input logic     rst,
  flfa_in_if.sink   in_ch,
  flfa_out_if.source out_ch,
  flfa_cfg_if.sink  cfg_ch
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [IW-1:0] LastK = IW'(MAX_BLOCKS - 1);

  state_t state, state_next;
  logic [2:0]           fit_policy;
  logic [2:0]           pol;
  logic [CW-1:0]        count;
  logic [IW-1:0]        rover;
  logic [IW-1:0]        start_pos;
  logic [IW-1:0]        k;
  logic [SIZE_BITS-1:0] req;
  logic [RandBits-1:0]  rnd;
  logic                 found, found_hi, picked;
  logic [IW-1:0]        sel, sel_hi;
  logic [SIZE_BITS-1:0] sel_size, size_hi;
  logic [CW-1:0]        cnt, target;
  logic                 res_removed;
  status_t              res_status;
  logic [IW-1:0]        res_idx;
  logic [SIZE_BITS-1:0] res_rem;

  cell_mode_t           cell_mode;
  logic [IW-1:0]        cell_pos;
  logic [SIZE_BITS-1:0] tail_in;
  logic [SIZE_BITS-1:0] cells [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] head;

  logic                 accept, fits, div_start, div_done;
  logic [CW-1:0]        div_rem;
  logic [IW-1:0]        ch_idx;
  logic [SIZE_BITS-1:0] ch_size;
  logic                 ch_removed;
  logic [CW-1:0]        cnt_new, rov_raw;

  assign head   = cells[0];
  assign accept = in_ch.valid && in_ch.ready;
  assign fits   = (CW'(k) < count) && (head >= req);
  assign cfg_ch.ready = 1'b1;

  // Chain of cells; the last one is fed from the head through tail_in.
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    flfa_cell #(.SIZE_BITS(SIZE_BITS), .IDX_BITS(IW), .CELL_POS(g)) u_cell (
      .clk  (clk),
      .mode (cell_mode),
      .pos  (cell_pos),
      .data (in_ch.size_value),
      .nbr  ((g == MAX_BLOCKS - 1) ? tail_in : cells[(g + 1) % MAX_BLOCKS]),
      .value(cells[g])
    );
  end

  // Remainder of the random value by the number of fitting blocks.
  flfa_mod #(.CNT_BITS(CW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(rnd),
    .divisor (cnt),
    .done    (div_done),
    .rem     (div_rem)
  );

  // Choice at the end of the walk, and the table bookkeeping that follows it.
  always_comb begin
    ch_idx     = (pol == POL_NEXT && found_hi) ? sel_hi : sel;
    ch_size    = (pol == POL_NEXT && found_hi) ? size_hi : sel_size;
    ch_removed = (ch_size == req);
    cnt_new    = ch_removed ? count - 1'b1 : count;
    if (ch_removed) begin
      if (pol == POL_NEXT) rov_raw = CW'(ch_idx);
      else if (ch_idx < rover) rov_raw = CW'(rover) - 1'b1;
      else rov_raw = CW'(rover);
    end else begin
      rov_raw = (pol == POL_NEXT) ? CW'(ch_idx) + 1'b1 : CW'(rover);
    end
  end

  // Next state and the commands to the cells.
  always_comb begin
    state_next  = state;
    cell_mode   = CELL_HOLD;
    cell_pos    = sel;
    tail_in     = head;
    div_start   = 1'b0;
    in_ch.ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          if (opcode_t'(in_ch.opcode) == OP_APPEND && count != CW'(MAX_BLOCKS)) begin
            cell_mode = CELL_APPEND;
            cell_pos  = count[IW-1:0];
          end
          if (opcode_t'(in_ch.opcode) == OP_ALLOCATE && fit_policy <= POL_RANDOM)
            state_next = S_SCAN;
        end
      end
      S_SCAN, S_PICK: begin
        cell_mode = CELL_ROTATE;
        if (k == LastK) state_next = S_EVAL;
      end
      S_DIV: begin
        if (div_done) state_next = S_PICK;
      end
      S_EVAL: begin
        if (pol == POL_RANDOM && !picked) begin
          if (cnt == '0) state_next = S_DONE;
          else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end else if (!found && !found_hi) state_next = S_DONE;
        else if (ch_removed) state_next = S_CLOSE;
        else state_next = S_UPDATE;
      end
      S_CLOSE: begin
        cell_mode  = CELL_CLOSE;
        state_next = S_DONE;
      end
      S_UPDATE: begin
        cell_mode = CELL_ROTATE;
        if (k == sel) tail_in = head - req;
        if (k == LastK) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_ch.valid || out_ch.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) fit_policy <= POL_FIRST;
    else if (cfg_ch.valid) fit_policy <= cfg_ch.fit_policy;
  end

  // Table control, walk bookkeeping and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rover <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            req         <= in_ch.size_value;
            rnd         <= in_ch.random_value;
            pol         <= fit_policy;
            k           <= '0;
            found       <= 1'b0;
            found_hi    <= 1'b0;
            picked      <= 1'b0;
            cnt         <= '0;
            start_pos   <= (CW'(rover) < count) ? rover : '0;
            res_status  <= ST_OK;
            res_idx     <= '0;
            res_rem     <= '0;
            res_removed <= 1'b0;
            case (opcode_t'(in_ch.opcode))
              OP_CLEAR: begin
                count <= '0;
                rover <= '0;
              end
              OP_APPEND: begin
                if (count == CW'(MAX_BLOCKS)) res_status <= ST_FULL;
                else begin
                  res_idx <= count[IW-1:0];
                  count   <= count + 1'b1;
                end
              end
              OP_ALLOCATE: begin
                if (fit_policy > POL_RANDOM) res_status <= ST_NO_FIT;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          k <= k + 1'b1;
          if (fits) begin
            cnt <= cnt + 1'b1;
            if (!found || (pol == POL_BEST && head < sel_size) ||
                (pol == POL_WORST && head > sel_size)) begin
              found    <= 1'b1;
              sel      <= k;
              sel_size <= head;
            end
            if (!found_hi && k >= start_pos && pol == POL_NEXT) begin
              found_hi <= 1'b1;
              sel_hi   <= k;
              size_hi  <= head;
            end
          end
        end
        S_DIV: begin
          target <= div_rem;
          found  <= 1'b0;
          k      <= '0;
        end
        S_PICK: begin
          k <= k + 1'b1;
          if (fits && !found) begin
            if (target == '0) begin
              found    <= 1'b1;
              sel      <= k;
              sel_size <= head;
            end else target <= target - 1'b1;
          end
          if (k == LastK) picked <= 1'b1;
        end
        S_EVAL: begin
          k <= '0;
          if (pol == POL_RANDOM && !picked) begin
            if (cnt == '0) res_status <= ST_NO_FIT;
          end else if (!found && !found_hi) res_status <= ST_NO_FIT;
          else begin
            sel         <= ch_idx;
            res_idx     <= ch_idx;
            res_removed <= ch_removed;
            res_rem     <= ch_removed ? '0 : ch_size - req;
            count       <= cnt_new;
            rover       <= (rov_raw >= cnt_new) ? '0 : rov_raw[IW-1:0];
          end
        end
        S_UPDATE: k <= k + 1'b1;
        default: ;
      endcase
    end
  end

  // Output register: loaded when the previous word has gone.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.valid           <= 1'b1;
      out_ch.status          <= res_status;
      out_ch.chosen_index    <= res_idx;
      out_ch.remaining_size  <= res_rem;
      out_ch.block_removed   <= res_removed;
      out_ch.block_count_out <= count;
    end else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

endmodule
